// ===== hdl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round functions of the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int WORD_DEPTH  = 16;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0]  PAD_FIRST = 8'h80;
	localparam logic [5:0]  LEN_START = 6'd56;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       message_last;
	} item_t;

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		unique case (r)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] round_s(input logic [5:0] r);
		logic [4:0] s;
		unique case ({r[5:4], r[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

	// Message word index used by round r.
	function automatic logic [3:0] round_g(input logic [5:0] r);
		logic [3:0] x;
		logic [3:0] g;
		x = r[3:0];
		unique case (r[5:4])
			2'd0: g = x;
			2'd1: g = 4'(x * 4'd5 + 4'd1);
			2'd2: g = 4'(x * 4'd3 + 4'd5);
			default: g = 4'(x * 4'd7);
		endcase
		return g;
	endfunction

	function automatic logic [31:0] round_f(input logic [1:0] phase,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		unique case (phase)
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (b & d) | (c & ~d);
			2'd2: f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] t;
		t = {v, v} << s;
		return t[63:32];
	endfunction

	function automatic logic [31:0] bswap(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

// ===== hdl/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 digest of a byte stream, one digest item per message.
// ----------------------------------------------------------------------------
// Channel    Direction  Payload
// s_axis     in         tdata: data_byte; tuser: has_byte; tlast: message_last
// m_axis     out        tdata: digest_high, digest_low
// digest_mode config    one-bit register, write enable plus data
//
// Each full block is compressed in 64 rounds, which share one word read port
// of the block buffer. A final item adds padding, one or two compressions and
// an output step, which waits while the previous digest item is stalled.
// A two-entry queue lets input items be taken while the engine is busy.
// Reset clears all control state; no clearing pass over the buffer is needed.
module md5_message_digest #(
	parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tuser,   // [0] has_byte
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [63:0] digest_high, [127:64] digest_low
	input  logic         digest_mode_we,
	input  logic         digest_mode_wdata
);

	logic           mode_q;
	logic           q_valid;
	logic           q_ready;
	md5_pkg::item_t q_item;
	logic [63:0]    high;
	logic [63:0]    low;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (digest_mode_we) begin
			mode_q <= digest_mode_wdata;
		end
	end

	md5_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_has   (s_tuser),
		.in_last  (s_tlast),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	md5_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.mode      (mode_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_high  (high),
		.out_low   (low)
	);

	assign m_tdata = {low, high};

endmodule

// ===== hdl/md5_ram.sv =====
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module md5_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/md5_front.sv =====
// ----------------------------------------------------------------------------
// md5_front
// Accepts input items, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module md5_front #(
	parameter int DEPTH = md5_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          in_has,
	input  logic          in_last,
	output logic          q_valid,
	input  logic          q_ready,
	output md5_pkg::item_t q_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	md5_pkg::item_t   slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      cnt_q;
	logic             push;
	logic             pop;
	md5_pkg::item_t   item;

	// Items that neither carry a byte nor end a message change nothing.
	always_comb begin
		item.data_byte    = in_byte;
		item.has_byte     = in_has;
		item.message_last = in_last;
	end

	assign in_ready = (cnt_q != (PW+1)'(DEPTH));
	assign push     = in_valid && in_ready && (in_has || in_last);
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_valid && q_ready;
	assign q_item   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
			end
			cnt_q <= (PW+1)'(cnt_q + (PW+1)'(push) - (PW+1)'(pop));
		end
	end

endmodule

// ===== hdl/md5_back.sv =====
// ----------------------------------------------------------------------------
// md5_back
// MD5 engine: block buffering, padding, 64-round compression, digest output.
// ----------------------------------------------------------------------------
module md5_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  md5_pkg::item_t q_item,
	input  logic           mode,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [63:0]    out_high,
	output logic [63:0]    out_low
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PAD    = 3'd1;
	localparam logic [2:0] ST_CLOAD  = 3'd2;
	localparam logic [2:0] ST_CROUND = 3'd3;
	localparam logic [2:0] ST_CADD   = 3'd4;
	localparam logic [2:0] ST_OUT    = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] ca_q, cb_q, cc_q, cd_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  r_q;
	logic [63:0] bit_count_q;
	logic [5:0]  fill_q;
	logic [23:0] acc_q;
	logic        pend_last_q;
	logic        padding_q;
	logic        pad_first_q;
	logic        len_phase_q;

	logic        push_en;
	logic [7:0]  push_byte;
	logic        wrap;
	logic        ram_we;
	logic [3:0]  ram_raddr;
	logic [31:0] ram_rdata;
	logic [31:0] sum;
	logic [31:0] new_b;
	logic        take_len;

	assign q_ready = (state_q == ST_IDLE);
	assign wrap    = (fill_q == 6'd63);
	assign take_len = !pad_first_q && (len_phase_q || fill_q == md5_pkg::LEN_START);

	always_comb begin
		push_en   = 1'b0;
		push_byte = q_item.data_byte;
		if (state_q == ST_IDLE) begin
			push_en = q_valid && q_item.has_byte;
		end else if (state_q == ST_PAD) begin
			push_en = 1'b1;
			priority if (pad_first_q) begin
				push_byte = md5_pkg::PAD_FIRST;
			end else if (take_len) begin
				push_byte = bit_count_q[8*fill_q[2:0] +: 8];
			end else begin
				push_byte = 8'h00;
			end
		end
	end

	assign ram_we    = push_en && (fill_q[1:0] == 2'd3);
	assign ram_raddr = (state_q == ST_CLOAD) ? 4'd0 : md5_pkg::round_g(6'(r_q + 1'b1));

	md5_ram #(
		.WIDTH(32),
		.DEPTH(md5_pkg::WORD_DEPTH)
	) u_words (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[5:2]),
		.wdata ({push_byte, acc_q}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign sum   = a_q + md5_pkg::round_f(r_q[5:4], b_q, c_q, d_q)
	             + md5_pkg::round_k(r_q) + ram_rdata;
	assign new_b = b_q + md5_pkg::rotl(sum, md5_pkg::round_s(r_q));

	always_ff @(posedge clk) begin
		if (push_en) begin
			unique case (fill_q[1:0])
				2'd0: acc_q[7:0]   <= push_byte;
				2'd1: acc_q[15:8]  <= push_byte;
				2'd2: acc_q[23:16] <= push_byte;
				default: ;
			endcase
		end
		if (state_q == ST_CLOAD) begin
			a_q <= ca_q;
			b_q <= cb_q;
			c_q <= cc_q;
			d_q <= cd_q;
		end else if (state_q == ST_CROUND) begin
			a_q <= d_q;
			b_q <= new_b;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ca_q        <= md5_pkg::IV_A;
			cb_q        <= md5_pkg::IV_B;
			cc_q        <= md5_pkg::IV_C;
			cd_q        <= md5_pkg::IV_D;
			r_q         <= '0;
			bit_count_q <= '0;
			fill_q      <= '0;
			pend_last_q <= 1'b0;
			padding_q   <= 1'b0;
			pad_first_q <= 1'b0;
			len_phase_q <= 1'b0;
			out_valid   <= 1'b0;
			out_high    <= '0;
			out_low     <= '0;
		end else begin
			if (out_valid && out_ready && state_q != ST_OUT) begin
				out_valid <= 1'b0;
			end
			if (push_en) begin
				fill_q <= 6'(fill_q + 1'b1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_item.has_byte) begin
							bit_count_q <= bit_count_q + 64'd8;
						end
						if (q_item.has_byte && wrap) begin
							pend_last_q <= q_item.message_last;
							state_q     <= ST_CLOAD;
						end else if (q_item.message_last) begin
							padding_q   <= 1'b1;
							pad_first_q <= 1'b1;
							len_phase_q <= 1'b0;
							state_q     <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					if (take_len) begin
						len_phase_q <= 1'b1;
					end
					if (wrap) begin
						state_q <= ST_CLOAD;
					end
				end
				ST_CLOAD: begin
					r_q     <= '0;
					state_q <= ST_CROUND;
				end
				ST_CROUND: begin
					r_q <= 6'(r_q + 1'b1);
					if (r_q == 6'd63) begin
						state_q <= ST_CADD;
					end
				end
				ST_CADD: begin
					ca_q <= ca_q + a_q;
					cb_q <= cb_q + b_q;
					cc_q <= cc_q + c_q;
					cd_q <= cd_q + d_q;
					priority if (padding_q && len_phase_q) begin
						state_q <= ST_OUT;
					end else if (padding_q) begin
						state_q <= ST_PAD;
					end else if (pend_last_q) begin
						pend_last_q <= 1'b0;
						padding_q   <= 1'b1;
						pad_first_q <= 1'b1;
						len_phase_q <= 1'b0;
						state_q     <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						if (mode) begin
							out_high <= {md5_pkg::bswap(cb_q), md5_pkg::bswap(cc_q)};
							out_low  <= '0;
						end else begin
							out_high <= {md5_pkg::bswap(ca_q), md5_pkg::bswap(cb_q)};
							out_low  <= {md5_pkg::bswap(cc_q), md5_pkg::bswap(cd_q)};
						end
						ca_q        <= md5_pkg::IV_A;
						cb_q        <= md5_pkg::IV_B;
						cc_q        <= md5_pkg::IV_C;
						cd_q        <= md5_pkg::IV_D;
						bit_count_q <= '0;
						padding_q   <= 1'b0;
						len_phase_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/md5_checker.sv =====
// ----------------------------------------------------------------------------
// md5_checker
// Port-level checks of the MD5 digest block, bound to the top level.
// ----------------------------------------------------------------------------
module md5_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic         digest_mode_we,
	input logic         digest_mode_wdata
);

	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (digest_mode_we) begin
			mode_q <= digest_mode_wdata;
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("digest item dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("digest item changed while stalled");

	// In short form the low half of the digest is always zero.
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && mode_q |-> m_tdata[127:64] == 64'd0)
		else $error("short digest has nonzero low half");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.m_tvalid          (m_tvalid),
	.m_tready          (m_tready),
	.m_tdata           (m_tdata),
	.digest_mode_we    (digest_mode_we),
	.digest_mode_wdata (digest_mode_wdata)
);

// ===== dv/md5_message_digest_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_message_digest_tb
// Streams byte messages into the MD5 digest block under random idling and
// checks every digest item against a behavioral MD5 model or a known digest,
// in both modes.
module md5_message_digest_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 300;

	typedef struct {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       message_last;
		logic       check_known;
		logic [127:0] known_digest;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic         digest_mode_we = 1'b0;
	logic         digest_mode_wdata = 1'b0;

	md5_message_digest u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.digest_mode_we(digest_mode_we), .digest_mode_wdata(digest_mode_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model state of the digest engine.
	logic [31:0] chain_a, chain_b, chain_c, chain_d;
	logic [63:0] msg_bits;
	logic [7:0]  blk_bytes [64];
	logic [5:0]  blk_fill;
	logic        short_form;

	logic [127:0] pending_digests [$];
	int  mismatch_count = 0;
	int  idle_count = 0;
	bit  quiet_phase = 0;

	function automatic logic [31:0] rot_left(logic [31:0] v, int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	task automatic compress_model();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t;
		int g, ph;
		int shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
		logic [31:0] kc [64] = '{
			32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
			32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
			32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
			32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
			32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
			32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
			32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
			32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
			32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
			32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
			32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
			32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
			32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
		for (int i = 0; i < 16; i++)
			w[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
		a = chain_a; b = chain_b; c = chain_c; d = chain_d;
		for (int r = 0; r < 64; r++) begin
			ph = r / 16;
			case (ph)
				0: begin f = (b & c) | (~b & d); g = r; end
				1: begin f = (b & d) | (c & ~d); g = (5*r + 1) % 16; end
				2: begin f = b ^ c ^ d; g = (3*r + 5) % 16; end
				default: begin f = c ^ (b | ~d); g = (7*r) % 16; end
			endcase
			t = d; d = c; c = b;
			b = b + rot_left(a + f + kc[r] + w[g], shifts[ph*4 + r%4]);
			a = t;
		end
		chain_a += a; chain_b += b; chain_c += c; chain_d += d;
	endtask

	task automatic append_byte(logic [7:0] v);
		blk_bytes[blk_fill] = v;
		blk_fill = blk_fill + 6'd1;
		if (blk_fill == 6'd0)
			compress_model();
	endtask

	task automatic restart_message();
		chain_a = md5_pkg::IV_A; chain_b = md5_pkg::IV_B;
		chain_c = md5_pkg::IV_C; chain_d = md5_pkg::IV_D;
		msg_bits = '0;
		blk_fill = '0;
	endtask

	// Digest bytes are A..D, each least significant byte first.
	function automatic logic [127:0] digest_bytes();
		return {md5_pkg::bswap(chain_a), md5_pkg::bswap(chain_b),
			md5_pkg::bswap(chain_c), md5_pkg::bswap(chain_d)};
	endfunction

	// Advances the model by one item; returns 1 with the packed tdata on a digest.
	task automatic predict_digest(logic [7:0] db, logic hb, logic ml,
			output bit produced, output logic [127:0] packed_out);
		logic [63:0] len;
		logic [127:0] dg;
		produced = 0;
		packed_out = '0;
		if (hb) begin
			msg_bits += 64'd8;
			append_byte(db);
		end
		if (!ml)
			return;
		len = msg_bits;
		append_byte(md5_pkg::PAD_FIRST);
		while (blk_fill != md5_pkg::LEN_START)
			append_byte(8'h00);
		for (int k = 0; k < 8; k++)
			append_byte(len[8*k +: 8]);
		dg = digest_bytes();
		if (short_form)
			packed_out = {64'h0, dg[95:32]};
		else
			packed_out = {dg[63:0], dg[127:64]};
		produced = 1;
		restart_message();
	endtask

	task automatic send_item(logic [7:0] db, logic hb, logic ml);
		int gap;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= db;
		s_tuser <= hb;
		s_tlast <= ml;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic issue_item(logic [7:0] db, logic hb, logic ml);
		bit got;
		logic [127:0] exp_v;
		predict_digest(db, hb, ml, got, exp_v);
		if (got)
			pending_digests.push_back(exp_v);
		send_item(db, hb, ml);
	endtask

	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		while (pending_digests.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(logic m);
		digest_mode_we <= 1'b1;
		digest_mode_wdata <= m;
		@(posedge clk);
		digest_mode_we <= 1'b0;
		short_form = m;
	endtask

	// Result side: random back-pressure outside the quiet phase, compare against oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_digests.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected digest item, expected none, actual %h",
						$time, m_tdata);
				end else begin
					logic [127:0] exp_v;
					exp_v = pending_digests.pop_front();
					if (m_tdata[63:0] !== exp_v[63:0]) begin
						mismatch_count++;
						$display("%0t: digest_high expected %h actual %h",
							$time, exp_v[63:0], m_tdata[63:0]);
					end
					if (m_tdata[127:64] !== exp_v[127:64]) begin
						mismatch_count++;
						$display("%0t: digest_low expected %h actual %h",
							$time, exp_v[127:64], m_tdata[127:64]);
					end
				end
			end
			m_tready <= quiet_phase ? 1'b1 : ($urandom_range(0, 2) != 0);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	stim_row_t directed [] = '{
		// Empty message digest.
		'{8'h00, 1'b0, 1'b1, 1'b1, {64'he9800998ecf8427e, 64'hd41d8cd98f00b204}},
		// Single byte 'a'.
		'{8'h61, 1'b1, 1'b1, 1'b1, {64'h31c399e269772661, 64'h0cc175b9c0f1b6a8}},
		'{8'h61, 1'b1, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, 1'b0, '0},
		'{8'h62, 1'b1, 1'b0, 1'b0, '0},
		'{8'h63, 1'b1, 1'b1, 1'b1, {64'hd6963f7d28e17f72, 64'h900150983cd24fb0}},
		'{8'hff, 1'b1, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b1, 1'b0, '0},
		'{8'h55, 1'b0, 1'b1, 1'b0, '0},
		'{8'haa, 1'b1, 1'b1, 1'b0, '0}
	};

	initial begin
		int msg_len;
		int sent;
		bit got;
		logic [127:0] exp_v;
		ref_init_done: begin
			short_form = 1'b0;
			restart_message();
			for (int i = 0; i < 64; i++)
				blk_bytes[i] = 8'h00;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			predict_digest(directed[i].data_byte, directed[i].has_byte,
				directed[i].message_last, got, exp_v);
			if (got)
				pending_digests.push_back(directed[i].check_known ?
					directed[i].known_digest : exp_v);
			send_item(directed[i].data_byte, directed[i].has_byte,
				directed[i].message_last);
		end
		drain_and_settle();

		sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			set_mode(phase[0]);
			if (phase == 3)
				quiet_phase = 1;
			while (sent < (phase + 1) * 280) begin
				// Lengths around the padding boundaries, with a few long messages.
				case ($urandom_range(0, 7))
					0: msg_len = $urandom_range(55, 57);
					1: msg_len = $urandom_range(63, 65);
					2: msg_len = $urandom_range(119, 129);
					3: msg_len = 0;
					default: msg_len = $urandom_range(1, 40);
				endcase
				for (int j = 0; j < msg_len; j++) begin
					if ($urandom_range(0, 15) == 0)
						issue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
					issue_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
					sent++;
				end
				issue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
				sent++;
			end
			drain_and_settle();
		end

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
